// ----- hdl/pscr_pkg.sv -----
package pscr_pkg;

   // Field widths of one item on either channel.
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 17;

   // Largest value the output byte counter can hold.
   localparam logic [COUNT_W-1:0] COUNT_FIELD_MAX = '1;

   // Raw byte that marks two stuffing bits after two zero bytes.
   localparam logic [BYTE_W-1:0] STUFF_BYTE = 8'h02;

   // Carry occupancy in bits.
   localparam logic [2:0] PC_NONE = 3'd0;
   localparam logic [2:0] PC_TWO  = 3'd2;
   localparam logic [2:0] PC_FOUR = 3'd4;
   localparam logic [2:0] PC_SIX  = 3'd6;

   // Masks that keep the top bits of a byte.
   localparam logic [BYTE_W-1:0] MASK_TWO  = 8'hc0;
   localparam logic [BYTE_W-1:0] MASK_FOUR = 8'hf0;
   localparam logic [BYTE_W-1:0] MASK_SIX  = 8'hfc;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Phase of the back part while it expands one queue entry.
   typedef enum logic {
      PH_FIRST,
      PH_FLUSH
   } pscr_phase_type;

   // One classified input item, carrying up to two results.
   typedef struct packed {
      logic [BYTE_W-1:0]  byte0;
      logic               byte0_valid;
      logic [BYTE_W-1:0]  flush_byte;
      logic               flush_valid;
      logic               last;
      logic [COUNT_W-1:0] count;
   } pscr_entry_type;

   // Mask that keeps the top bits for a given carry count.
   function automatic logic [BYTE_W-1:0] keep_mask(input logic [2:0] pc);
      logic [BYTE_W-1:0] m;
      case (pc)
         PC_TWO:  m = MASK_TWO;
         PC_FOUR: m = MASK_FOUR;
         PC_SIX:  m = MASK_SIX;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

// ----- hdl/pscr_req_if.sv -----
interface pscr_req_if;
   import pscr_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              is_last;

   modport source (output valid, output in_byte, output is_last, input ready);
   modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

// ----- hdl/pscr_rsp_if.sv -----
interface pscr_rsp_if;
   import pscr_pkg::*;

   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  out_byte;
   logic               byte_valid;
   logic               end_of_packet;
   logic [COUNT_W-1:0] out_count;

   modport source (output valid, output out_byte, output byte_valid,
                   output end_of_packet, output out_count, input ready);
   modport sink   (input valid, input out_byte, input byte_valid,
                   input end_of_packet, input out_count, output ready);
endinterface

// ----- hdl/pscr_front.sv -----
module pscr_front #(
   parameter int unsigned MAX_PACKET_BYTES = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   pscr_req_if.sink               req_chan,
   input  logic                   queue_full,
   output logic                   push,
   output pscr_pkg::pscr_entry_type push_entry
);
   import pscr_pkg::*;

   // Saturation point of the output byte counter.
   localparam logic [COUNT_W-1:0] COUNT_LIMIT =
      (MAX_PACKET_BYTES < 32'(COUNT_FIELD_MAX)) ? COUNT_W'(MAX_PACKET_BYTES) : COUNT_FIELD_MAX;

   logic [BYTE_W-1:0]  older_raw_ff, older_raw_in;
   logic [BYTE_W-1:0]  newer_raw_ff, newer_raw_in;
   logic [1:0]         bytes_seen_ff, bytes_seen_in;
   logic [BYTE_W-1:0]  pending_bits_ff, pending_bits_in;
   logic [2:0]         pending_count_ff, pending_count_in;
   logic [COUNT_W-1:0] emitted_ff, emitted_in;

   logic                accept;
   logic                stuffed;
   logic [BYTE_W-1:0]   merged;
   logic [2*BYTE_W-1:0] wide_shift;
   logic [BYTE_W-1:0]   shifted;
   logic [BYTE_W-1:0]   byte0;
   logic                byte0_valid;
   logic                flush;
   logic [1:0]          puts;
   logic [COUNT_W:0]    count_sum;
   logic [COUNT_W-1:0]  count_next;

   assign req_chan.ready = !queue_full;
   assign accept = req_chan.valid && !queue_full;

   // Classify the byte and work out the repacked output and the new carry.
   always_comb begin
      stuffed = (older_raw_ff == '0) && (newer_raw_ff == '0) &&
                (req_chan.in_byte == STUFF_BYTE);
      merged = (pending_bits_ff & keep_mask(pending_count_ff)) |
               ((req_chan.in_byte & keep_mask(3'(4'd8 - {1'b0, pending_count_ff})))
                >> pending_count_ff);
      wide_shift = {{BYTE_W{1'b0}}, req_chan.in_byte} << (4'd8 - {1'b0, pending_count_ff});
      shifted = wide_shift[BYTE_W-1:0];

      byte0 = '0;
      byte0_valid = 1'b0;
      bytes_seen_in = bytes_seen_ff;
      pending_bits_in = pending_bits_ff;
      pending_count_in = pending_count_ff;

      if (bytes_seen_ff < 2'd2) begin
         byte0 = req_chan.in_byte;
         byte0_valid = 1'b1;
         bytes_seen_in = 2'(bytes_seen_ff + 2'd1);
      end else if (!stuffed) begin
         byte0_valid = 1'b1;
         if (pending_count_ff == PC_NONE) begin
            byte0 = req_chan.in_byte;
         end else begin
            byte0 = merged;
            pending_bits_in = shifted & keep_mask(pending_count_ff);
         end
      end else if (pending_count_ff == PC_NONE) begin
         // A lone stuffing byte is kept as it came in.
         pending_bits_in = req_chan.in_byte;
         pending_count_in = PC_SIX;
      end else begin
         byte0_valid = 1'b1;
         byte0 = merged;
         pending_bits_in = shifted & keep_mask(3'(pending_count_ff - PC_TWO));
         pending_count_in = 3'(pending_count_ff - PC_TWO);
      end

      flush = req_chan.is_last && (pending_count_in != PC_NONE) && (pending_bits_in != '0);

      // Saturating count of bytes put out so far.
      puts = {1'b0, byte0_valid} + {1'b0, flush};
      count_sum = {1'b0, emitted_ff} + (COUNT_W+1)'(puts);
      count_next = (count_sum > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT : count_sum[COUNT_W-1:0];

      older_raw_in = newer_raw_ff;
      newer_raw_in = req_chan.in_byte;
      emitted_in = count_next;
   end

   // Only items that produce a result are queued.
   always_comb begin
      push = accept && (byte0_valid || req_chan.is_last);
      push_entry.byte0 = byte0;
      push_entry.byte0_valid = byte0_valid;
      push_entry.flush_byte = pending_bits_in;
      push_entry.flush_valid = flush;
      push_entry.last = req_chan.is_last;
      push_entry.count = count_next;
   end

   // Packet state; the final byte returns it to the start of a packet.
   always_ff @(posedge clock) begin
      if (reset || (accept && req_chan.is_last)) begin
         older_raw_ff <= '0;
         newer_raw_ff <= '0;
         bytes_seen_ff <= '0;
         pending_bits_ff <= '0;
         pending_count_ff <= PC_NONE;
         emitted_ff <= '0;
      end else if (accept) begin
         older_raw_ff <= older_raw_in;
         newer_raw_ff <= newer_raw_in;
         bytes_seen_ff <= bytes_seen_in;
         pending_bits_ff <= pending_bits_in;
         pending_count_ff <= pending_count_in;
         emitted_ff <= emitted_in;
      end
   end

`ifndef SYNTHESIS
   // The carry is always a whole number of bit pairs, at most six.
   a_carry_even: assert property (@(posedge clock) disable iff (reset)
      (pending_count_ff[0] == 1'b0) && (pending_count_ff <= PC_SIX))
      else $error("carry count out of range");

   // The counter never passes its saturation point.
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      emitted_ff <= COUNT_LIMIT)
      else $error("output count past its limit");

   // After the final byte the packet state is back at its start.
   a_packet_end: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.is_last) |=>
         (bytes_seen_ff == 2'd0) && (pending_count_ff == PC_NONE) && (emitted_ff == '0))
      else $error("packet state not cleared at end of packet");
`endif
endmodule

// ----- hdl/pscr_queue.sv -----
module pscr_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  pscr_pkg::pscr_entry_type push_entry,
   output logic                    full,
   input  logic                    pop,
   output logic                    head_valid,
   output pscr_pkg::pscr_entry_type head_entry
);
   import pscr_pkg::*;

   pscr_entry_type      entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   fill_ff, fill_in;

   assign full = (fill_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = push ? QUEUE_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QUEUE_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in = fill_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   // The queue is never written while full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   // The queue is never read while empty.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");
`endif
endmodule

// ----- hdl/pscr_back.sv -----
module pscr_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  pscr_pkg::pscr_entry_type head_entry,
   output logic                    pop,
   pscr_rsp_if.source              rsp_chan
);
   import pscr_pkg::*;

   pscr_phase_type     phase_ff, phase_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic               byte_valid_ff, byte_valid_in;
   logic               eop_ff, eop_in;
   logic [COUNT_W-1:0] out_count_ff, out_count_in;

   logic out_free;
   logic first_exists;
   logic load;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.out_byte = out_byte_ff;
   assign rsp_chan.byte_valid = byte_valid_ff;
   assign rsp_chan.end_of_packet = eop_ff;
   assign rsp_chan.out_count = out_count_ff;

   // Expand the head entry into its results, one per cycle while rsp_chan is not stalled.
   always_comb begin
      out_free = !rsp_valid_ff || rsp_chan.ready;
      first_exists = head_entry.byte0_valid || (head_entry.last && !head_entry.flush_valid);
      pop = 1'b0;
      load = 1'b0;
      phase_in = phase_ff;
      out_byte_in = out_byte_ff;
      byte_valid_in = byte_valid_ff;
      eop_in = eop_ff;
      out_count_in = out_count_ff;

      if (head_valid) begin
         if ((phase_ff == PH_FIRST) && first_exists) begin
            if (out_free) begin
               load = 1'b1;
               out_byte_in = head_entry.byte0_valid ? head_entry.byte0 : '0;
               byte_valid_in = head_entry.byte0_valid;
               eop_in = head_entry.last && !head_entry.flush_valid;
               out_count_in = eop_in ? head_entry.count : '0;
               if (head_entry.flush_valid) begin
                  phase_in = PH_FLUSH;
               end else begin
                  pop = 1'b1;
               end
            end
         end else if (head_entry.flush_valid) begin
            // Flush of the carry closes the packet.
            if (out_free) begin
               load = 1'b1;
               out_byte_in = head_entry.flush_byte;
               byte_valid_in = 1'b1;
               eop_in = 1'b1;
               out_count_in = head_entry.count;
               pop = 1'b1;
               phase_in = PH_FIRST;
            end
         end else begin
            pop = 1'b1;
         end
      end

      rsp_valid_in = load || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         out_byte_ff <= out_byte_in;
         byte_valid_ff <= byte_valid_in;
         eop_ff <= eop_in;
         out_count_ff <= out_count_in;
      end
   end

`ifndef SYNTHESIS
   // The flush phase only exists while its entry is still queued.
   a_flush_has_head: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FLUSH) |-> (head_valid && head_entry.flush_valid))
      else $error("flush phase without a flushing entry");

   // A count is only reported on the closing result.
   a_count_on_eop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !eop_ff) |-> (out_count_ff == '0))
      else $error("count reported on a result that does not close the packet");
`endif
endmodule

// ----- hdl/pseudo_start_code_remover.sv -----
// Channel   Dir  Handshake          Payload
// req_chan  in   valid / ready      in_byte[7:0], is_last
// rsp_chan  out  valid / ready      out_byte[7:0], byte_valid, end_of_packet, out_count[16:0]
//
// One input item is taken per cycle while the queue is not full; each item is classified
// in the cycle it is taken by the front part, which holds the two-byte history and the bit carry.
// The final item of a packet can yield two results (byte and carry flush), which the
// back part delivers one after the other; a four-entry queue lies between the two parts.
// Reset is synchronous and clears all control state.
// A stall on rsp_chan fills the queue; req_chan.ready drops only when it is full.
module pseudo_start_code_remover #(
   parameter int unsigned MAX_PACKET_BYTES = 65536
) (
   input  logic       clock,
   input  logic       reset,
   pscr_req_if.sink   req_chan,
   pscr_rsp_if.source rsp_chan
);
   import pscr_pkg::*;

   logic           queue_full;
   logic           push;
   pscr_entry_type push_entry;
   logic           pop;
   logic           head_valid;
   pscr_entry_type head_entry;

   pscr_front #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   pscr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   pscr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );
endmodule
